/* sv/frbt_pkg.sv */
// frbt_pkg: shared types and constants of the float to binary token unit.
// No dependencies; imported by every module of the block.
package frbt_pkg;

   localparam int unsigned FLOAT_W    = 32;
   localparam int unsigned BYTE_W     = 8;
   localparam int unsigned TOKEN_MAX  = 5;
   localparam int unsigned LEN_W      = 3;
   localparam int unsigned QDEPTH     = 2;
   localparam int unsigned QPTR_W     = 1;
   localparam int unsigned QCNT_W     = 2;

   // Header byte of the four-byte IEEE form (octal 0244)
   localparam logic [BYTE_W-1:0] HDR_IEEE  = 8'hA4;
   // Base of the fixed-point header (octal 0200)
   localparam logic [BYTE_W-1:0] HDR_FIXED = 8'h80;

   localparam logic [7:0] EXP_LO = 8'd122;
   localparam logic [7:0] EXP_HI = 8'd141;

   // One encoded token: length 2..5, byte 0 is the header
   typedef struct packed {
      logic [LEN_W-1:0]                   len;
      logic [TOKEN_MAX-1:0][BYTE_W-1:0]   bytes;
   } token_type;

endpackage

/* sv/frbt_front.sv */
// frbt_front: classifies one float pattern and builds its whole token.
// Depends on frbt_pkg.
module frbt_front
   import frbt_pkg::*;
(
   input  logic               ieee_only,
   input  logic [FLOAT_W-1:0] float_bits,
   output token_type          token
);

   logic [7:0]          expo;
   logic                in_range;
   logic [FLOAT_W-1:0]  frac;
   logic [FLOAT_W-1:0]  frac_neg;
   logic [2:0]          sh;
   logic signed [3:0]   d0;
   logic [FLOAT_W-1:0]  fsh;
   logic [FLOAT_W-1:0]  rem;
   logic signed [3:0]   d;
   logic [1:0]          w;
   logic                fail;
   logic [2:0][BYTE_W-1:0] fb;
   logic [1:0]          wm1;

   assign expo     = float_bits[30:23];
   assign in_range = (expo >= EXP_LO) && (expo <= EXP_HI);
   assign frac     = {8'd0, 1'b1, float_bits[22:0]};
   assign frac_neg = float_bits[31] ? (~frac + 32'd1) : frac;

   // shift and initial fraction-byte count from the exponent
   always_comb begin
      if (expo <= 8'd125) begin
         sh = 3'(expo - 8'd118);
         d0 = 4'sd0;
      end else if (expo == 8'd126) begin
         sh = 3'd0;
         d0 = -4'sd1;
      end else if (expo <= 8'd133) begin
         sh = 3'(expo - 8'd126);
         d0 = -4'sd1;
      end else begin
         sh = 3'(expo - 8'd134);
         d0 = -4'sd2;
      end
   end

   assign fsh = frac_neg << sh;

   // at most four byte-take steps; a fourth byte means failure
   always_comb begin
      rem  = fsh;
      d    = d0;
      w    = 2'd0;
      fail = 1'b0;
      fb   = '0;
      for (int k = 0; k < 4; k++) begin
         if (((rem != '0) && (d < 4'sd3)) || (d < 4'sd0)) begin
            if (k == 3) begin
               fail = 1'b1;
            end else begin
               fb[k] = rem[31:24];
               w     = 2'(k + 1);
               d     = d + 4'sd1;
               rem   = rem << 8;
            end
         end
      end
      if (w == 2'd0) begin
         fail = 1'b1;
      end
   end

   assign wm1 = w - 2'd1;

   always_comb begin
      if (ieee_only || !in_range || fail) begin
         token.len      = LEN_W'(TOKEN_MAX);
         token.bytes[0] = HDR_IEEE;
         token.bytes[1] = float_bits[31:24];
         token.bytes[2] = float_bits[23:16];
         token.bytes[3] = float_bits[15:8];
         token.bytes[4] = float_bits[7:0];
      end else begin
         token.len      = LEN_W'({1'b0, w}) + LEN_W'(1);
         token.bytes[0] = HDR_FIXED | {4'd0, d[1:0], wm1};
         token.bytes[1] = fb[0];
         token.bytes[2] = fb[1];
         token.bytes[3] = fb[2];
         token.bytes[4] = '0;
      end
   end

endmodule

/* sv/frbt_queue.sv */
// frbt_queue: two-entry token queue between front and back.
// Depends on frbt_pkg.
module frbt_queue
   import frbt_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      enq_valid,
   output logic      enq_ready,
   input  token_type enq_data,
   output logic      deq_valid,
   input  logic      deq_pop,
   output token_type deq_data
);

   token_type           ent_ff [QDEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   cnt_ff, cnt_in;
   logic                do_enq;
   logic                do_deq;

   assign enq_ready = (cnt_ff != QCNT_W'(QDEPTH));
   assign deq_valid = (cnt_ff != '0);
   assign deq_data  = ent_ff[rd_ptr_ff];
   assign do_enq    = enq_valid && enq_ready;
   assign do_deq    = deq_pop && deq_valid;

   always_comb begin
      wr_ptr_in = do_enq ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_deq ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      cnt_in    = cnt_ff + QCNT_W'(do_enq) - QCNT_W'(do_deq);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_enq) begin
         ent_ff[wr_ptr_ff] <= enq_data;
      end
   end

endmodule

/* sv/frbt_back.sv */
// frbt_back: serialises queued tokens into byte beats through an output register.
// Depends on frbt_pkg.
module frbt_back
   import frbt_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              tok_valid,
   input  token_type         tok_data,
   output logic              tok_pop,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [BYTE_W-1:0] out_byte,
   output logic              out_last
);

   logic [(TOKEN_MAX-1)*BYTE_W-1:0] sh_ff, sh_in;
   logic [LEN_W-1:0]                rem_ff, rem_in;
   logic                            vld_ff, vld_in;
   logic [BYTE_W-1:0]               byte_ff, byte_in;
   logic                            last_ff, last_in;
   logic                            slot_free;

   assign slot_free = !vld_ff || out_ready;

   always_comb begin
      sh_in   = sh_ff;
      rem_in  = rem_ff;
      vld_in  = vld_ff && !out_ready;
      byte_in = byte_ff;
      last_in = last_ff;
      tok_pop = 1'b0;
      if (slot_free) begin
         if (rem_ff != '0) begin
            vld_in  = 1'b1;
            byte_in = sh_ff[BYTE_W-1:0];
            last_in = (rem_ff == LEN_W'(1));
            sh_in   = sh_ff >> BYTE_W;
            rem_in  = rem_ff - LEN_W'(1);
         end else if (tok_valid) begin
            // header beat; a token always has at least one more byte
            vld_in  = 1'b1;
            byte_in = tok_data.bytes[0];
            last_in = 1'b0;
            sh_in   = tok_data.bytes[TOKEN_MAX-1:1];
            rem_in  = tok_data.len - LEN_W'(1);
            tok_pop = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff <= '0;
         vld_ff <= 1'b0;
      end else begin
         rem_ff <= rem_in;
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      sh_ff   <= sh_in;
      byte_ff <= byte_in;
      last_ff <= last_in;
   end

   assign out_valid = vld_ff;
   assign out_byte  = byte_ff;
   assign out_last  = last_ff;

endmodule

/* sv/float_to_rib_binary_token_unit.sv */
// float_to_rib_binary_token_unit: top level of the float to binary token encoder.
// Depends on frbt_pkg, frbt_front, frbt_queue and frbt_back.
//
//  channel | dir | beat contents                      | handshake
//  --------+-----+------------------------------------+--------------------
//  req     | in  | tdata[31:0] float_bits             | req_tvalid/tready
//  rsp     | out | tdata[7:0] out_byte, tlast = last  | rsp_tvalid/tready
//  csr     | in  | csr_wdata = ieee_only              | csr_wen, no wait
//
// Each value becomes a token of 2 to 5 beats (5 for the IEEE form); the back end
// serialiser emits one beat per cycle while rsp_tready is high. The first beat
// passes through the queue and then the back end's output register. The front
// encodes in the accept cycle into a two-entry queue, so the input keeps flowing,
// until that queue is full, while a token is stalled on rsp.
// Reset is synchronous: queue and serialiser empty, ieee_only cleared.
module float_to_rib_binary_token_unit
   import frbt_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [FLOAT_W-1:0] req_tdata,   // [31:0] float_bits
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [BYTE_W-1:0]  rsp_tdata,   // [7:0] out_byte
   output logic               rsp_tlast,
   input  logic               csr_wen,
   input  logic               csr_wdata
);

   logic      ieee_only_ff, ieee_only_in;
   token_type front_tok;
   token_type q_tok;
   logic      q_valid;
   logic      q_pop;

   // single config bit, to be written by the user only while idle; the block itself does not enforce this
   assign ieee_only_in = csr_wen ? csr_wdata : ieee_only_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ieee_only_ff <= 1'b0;
      end else begin
         ieee_only_ff <= ieee_only_in;
      end
   end

   // front: whole token built in the accept cycle
   frbt_front u_front (
      .ieee_only  (ieee_only_ff),
      .float_bits (req_tdata),
      .token      (front_tok)
   );

   // decoupling queue; req_tready is simply "queue not full"
   frbt_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .enq_valid (req_tvalid),
      .enq_ready (req_tready),
      .enq_data  (front_tok),
      .deq_valid (q_valid),
      .deq_pop   (q_pop),
      .deq_data  (q_tok)
   );

   // back: one beat per cycle while rsp_tready is high, output register parts it from rsp
   frbt_back u_back (
      .clock     (clock),
      .reset     (reset),
      .tok_valid (q_valid),
      .tok_data  (q_tok),
      .tok_pop   (q_pop),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_byte  (rsp_tdata),
      .out_last  (rsp_tlast)
   );

endmodule

/* sv/frbt_checker.sv */
// frbt_checker: port-level checks of the token stream, bound to the top level.
// Depends on frbt_pkg and float_to_rib_binary_token_unit.
module frbt_checker
   import frbt_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_tready,
   input logic               rsp_tvalid,
   input logic               rsp_tready,
   input logic [BYTE_W-1:0]  rsp_tdata,
   input logic               rsp_tlast
);

   logic             first_ff;
   logic [LEN_W-1:0] beat_ff;

   // track where we are inside a token
   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff <= 1'b1;
         beat_ff  <= '0;
      end else if (rsp_tvalid && rsp_tready) begin
         first_ff <= rsp_tlast;
         beat_ff  <= rsp_tlast ? '0 : beat_ff + LEN_W'(1);
      end
   end

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> (!rsp_tvalid && req_tready))
      else $error("outputs not idle after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
         (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast)))
      else $error("stalled rsp beat changed");

   a_header: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && first_ff) |-> (rsp_tdata[7] && !rsp_tlast))
      else $error("token header malformed or token too short");

   a_max_len: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (beat_ff == LEN_W'(TOKEN_MAX - 1))) |-> rsp_tlast)
      else $error("token longer than five beats");

endmodule

bind float_to_rib_binary_token_unit frbt_checker u_frbt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

/* sim/tb_float_to_rib_binary_token_unit.sv */
// tb_float_to_rib_binary_token_unit: self-checking bench for the float to binary token encoder.
// Depends on frbt_pkg and float_to_rib_binary_token_unit; the token predictor lives in a
// small scoreboard class, always blocks drive the req and rsp ports and a task the csr port.
`timescale 1ns / 1ps

module tb_float_to_rib_binary_token_unit
   import frbt_pkg::*;
();

   localparam int CYCLE_LIMIT = 100000;
   localparam int EXP_BIAS    = 127;
   localparam int IDLE_PCT    = 28;       // percent chance of idling on either side
   localparam int STEADY_FROM = 100;      // values in this window are sent with no idling
   localparam int STEADY_TO   = 180;

   // Scoreboard: holds a private copy of ieee_only and the beats still owed by the block.
   class token_scoreboard;
      logic              ieee_only;
      logic [BYTE_W-1:0] token_bytes[$];
      logic              token_lasts[$];
      int                errors;

      function new();
         ieee_only = 1'b0;
         errors    = 0;
      endfunction

      // Works out the token for one accepted value and queues its beats.
      function void note_value(logic [FLOAT_W-1:0] bits);
         logic [BYTE_W-1:0] tok[TOKEN_MAX];
         logic [31:0]       frac;
         int                expo;
         int                ue;
         int                shift;
         int                d;
         int                w;
         int                n;
         bit                fits;
         n    = 0;
         expo = int'(bits[30:23]);
         if (!ieee_only && expo >= int'(EXP_LO) && expo <= int'(EXP_HI)) begin
            ue   = expo - EXP_BIAS;
            frac = {8'h00, 1'b1, bits[22:0]};
            if (bits[31]) begin
               frac = ~frac + 32'd1;
            end
            // byte alignment of the binary point
            if (ue < 0) begin
               shift = (ue + 9) % 8;
               d     = (ue == -1) ? -1 : 0;
            end else begin
               shift = (ue + 1) % 8;
               d     = -(((ue + 1) >> 3) + 1);
            end
            frac = frac << shift;
            w    = 0;
            fits = 1'b1;
            while (fits && ((frac != 32'd0 && d < 3) || d < 0)) begin
               w++;
               d++;
               if (w > 3) begin
                  fits = 1'b0;
               end else begin
                  tok[w] = frac[31:24];
                  frac   = frac << 8;
               end
            end
            if (fits && w >= 1) begin
               tok[0] = HDR_FIXED + BYTE_W'(d * 4 + w - 1);
               n      = w + 1;
            end
         end
         if (n == 0) begin
            tok[0] = HDR_IEEE;
            tok[1] = bits[31:24];
            tok[2] = bits[23:16];
            tok[3] = bits[15:8];
            tok[4] = bits[7:0];
            n      = 5;
         end
         for (int k = 0; k < n; k++) begin
            token_bytes.push_back(tok[k]);
            token_lasts.push_back(k == n - 1);
         end
      endfunction

      // Compares one accepted rsp beat with the oldest owed beat.
      function void check_beat(logic [BYTE_W-1:0] data, logic last);
         logic [BYTE_W-1:0] exp_byte;
         logic              exp_last;
         if (token_bytes.size() == 0) begin
            $error("unexpected beat: out_byte %02h last %0d", data, last);
            errors++;
         end else begin
            exp_byte = token_bytes.pop_front();
            exp_last = token_lasts.pop_front();
            if (data !== exp_byte) begin
               $error("out_byte: expected %02h, got %02h", exp_byte, data);
               errors++;
            end
            if (last !== exp_last) begin
               $error("last: expected %0d, got %0d", exp_last, last);
               errors++;
            end
         end
      endfunction
   endclass

   // Every input starts at a known level.
   logic               clock      = 1'b0;
   logic               reset      = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [FLOAT_W-1:0] req_tdata  = '0;   // [31:0] float_bits
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [BYTE_W-1:0]  rsp_tdata;         // [7:0] out_byte
   logic               rsp_tlast;
   logic               csr_wen    = 1'b0;
   logic               csr_wdata  = 1'b0;

   token_scoreboard    sb = new();
   logic [FLOAT_W-1:0] value_q[$];        // values waiting to be offered on req
   int                 sent_count = 0;
   logic               steady     = 1'b0; // both sides stop idling while set
   int                 cycle_count = 0;

   float_to_rib_binary_token_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata)
   );

   always #10 clock = ~clock;

   // req driver: a new beat is offered only once the slot is free, so tvalid gets a
   // single update per edge and stays high across back-to-back beats.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (value_q.size() != 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
            req_tvalid <= 1'b1;
            req_tdata  <= value_q.pop_front();
            sent_count <= sent_count + 1;
            steady     <= (sent_count + 1 >= STEADY_FROM) && (sent_count + 1 < STEADY_TO);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // rsp back-pressure: random stalls, none during the steady window
   always @(posedge clock) begin
      rsp_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
   end

   // Monitor: inputs are noted before outputs are checked within one edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            sb.note_value(req_tdata);
         end
         if (rsp_tvalid && rsp_tready) begin
            sb.check_beat(rsp_tdata, rsp_tlast);
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_float_to_rib_binary_token_unit: FAIL");
         $finish;
      end
   end

   // Blocks until nothing is queued, offered or owed. Checked mid-cycle so that the
   // edge's driver and monitor updates have all settled; returns on a rising edge.
   task automatic wait_drained();
      @(negedge clock);
      while (value_q.size() != 0 || req_tvalid || sb.token_bytes.size() != 0) begin
         @(negedge clock);
      end
      @(posedge clock);
   endtask

   // ieee_only is only ever written with the block drained.
   task automatic write_ieee_only(logic value);
      wait_drained();
      csr_wen   <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_wen   <= 1'b0;
      sb.ieee_only = value;
   endtask

   // Random value: mostly inside the fixed-point exponent window, often with a short
   // mantissa so that the one to three byte forms turn up; the rest near the window
   // edges or fully random.
   function automatic logic [FLOAT_W-1:0] random_float();
      logic [FLOAT_W-1:0] v;
      int                 pick;
      int                 keep;
      pick = $urandom_range(0, 99);
      v    = $urandom;
      if (pick < 65) begin
         v[30:23] = 8'($urandom_range(int'(EXP_LO), int'(EXP_HI)));
         if (pick < 40) begin
            keep     = $urandom_range(0, 23);
            v[22:0]  = v[22:0] & ~(23'h7FFFFF >> keep);
         end
      end else if (pick < 75) begin
         v[30:23] = 8'($urandom_range(int'(EXP_LO) - 3, int'(EXP_HI) + 3));
      end
      return v;
   endfunction

   initial begin
      logic [FLOAT_W-1:0] edge_values[$] = '{
         32'h0000_0000, 32'h8000_0000,   // signed zeros
         32'h0000_0001, 32'h807F_FFFF,   // denormals
         32'h7F80_0000, 32'hFF80_0000,   // infinities
         32'h7FC0_0000, 32'hFFFF_FFFF,   // NaNs
         32'h3C80_0000, 32'hBCFF_FFFF,   // exponent just below the window
         32'h3D00_0000, 32'hBD00_0000,   // lowest exponent in the window
         32'h3F00_0000, 32'hBF00_0000,   // 0.5: one fraction byte ahead of the point
         32'h3F80_0000, 32'hBF80_0000,   // +-1.0
         32'h3F80_0001, 32'h3F7F_FFFF,   // too many bytes: IEEE form
         32'h437F_0000, 32'h4380_0000,   // 255 and 256
         32'hC380_0000, 32'h4480_0000,
         32'h4600_0000, 32'hC67F_FFFF,   // exponent 140, one below the top of the window
         32'h4700_0000, 32'h7F7F_FFFF    // above the window
      };

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed corners and random values, fixed-point form allowed
      write_ieee_only(1'b0);
      foreach (edge_values[i]) begin
         value_q.push_back(edge_values[i]);
      end
      repeat (171) value_q.push_back(random_float());

      // every value forced to the IEEE form
      write_ieee_only(1'b1);
      value_q.push_back(32'h3F80_0000);
      repeat (80) value_q.push_back(random_float());

      // back to the compact form after a forced phase
      write_ieee_only(1'b0);
      repeat (130) value_q.push_back(random_float());

      wait_drained();
      repeat (12) @(posedge clock);
      if (sb.errors == 0 && sb.token_bytes.size() == 0) begin
         $display("tb_float_to_rib_binary_token_unit: PASS");
      end else begin
         $display("tb_float_to_rib_binary_token_unit: FAIL");
      end
      $finish;
   end

endmodule
